// ===== src/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// tps_pkg: thermal profile sequencer shared definitions
// Field widths, state codes, operation codes, register indexes and the
// reset values of the sequencer state.
// ----------------------------------------------------------------------------
package tps_pkg;

   // field widths
   localparam int TEMP_W      = 16;
   localparam int OP_W        = 2;
   localparam int MODE_W      = 2;
   localparam int PHASE_W     = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int STEP_W      = 15;
   localparam int CNT_W       = 16;
   localparam int SETTLE_W    = 14;
   localparam int HOLD_W      = 23;

   // default tuning, 100 Hz tick base
   localparam int DEF_TICKS_PER_SECOND = 100;
   localparam int DEF_SETTLE_TICKS     = 50;
   localparam int DEF_BAND_WIDTH       = 50;
   localparam int DEF_COOL_TARGET      = 2500;

   // counter limits
   localparam logic [SETTLE_W-1:0] SETTLE_SAT = 14'd10000;
   localparam logic [HOLD_W-1:0]   HOLD_MAX   = 23'h7FFFFF;
   localparam logic [STEP_W-1:0]   STEP_ZERO_SUBST = 15'd100;

   // reset values, 0.01 C units
   localparam logic signed [TEMP_W-1:0] RST_TARGET    = 16'sd6000;
   localparam logic signed [TEMP_W-1:0] RST_STEP_LO   = 16'sd3000;
   localparam logic signed [TEMP_W-1:0] RST_STEP_HI   = 16'sd8000;
   localparam logic signed [TEMP_W-1:0] RST_SETPOINT  = 16'sd2500;
   localparam logic [STEP_W-1:0]        RST_STEP_SIZE = 15'd1000;

   typedef enum logic [OP_W-1:0] {
      OP_TICK     = 2'd0,
      OP_ISO      = 2'd1,
      OP_STEP     = 2'd2,
      OP_SETPOINT = 2'd3
   } op_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_IDLE = 2'd0,
      MODE_ISO  = 2'd1,
      MODE_STEP = 2'd2
   } mode_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_HEAT = 2'd0,
      PH_HOLD = 2'd1,
      PH_COOL = 2'd2
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CYCLE_COUNT  = 3'd0,
      CSR_HOLD_SECONDS = 3'd1,
      CSR_STEP_START   = 3'd2,
      CSR_STEP_STOP    = 3'd3,
      CSR_STEP_SIZE    = 3'd4
   } csr_idx_type;

endpackage

// ===== src/tps_ifs.sv =====
// ----------------------------------------------------------------------------
// tps_ifs: thermal profile sequencer channels
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------

// command channel
interface tps_req_if
   import tps_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic signed [TEMP_W-1:0] measured_temp;
   logic signed [TEMP_W-1:0] setpoint_value;

   modport source (output valid, operation, measured_temp, setpoint_value, input ready);
   modport sink   (input valid, operation, measured_temp, setpoint_value, output ready);
endinterface

// result channel
interface tps_rsp_if
   import tps_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] setpoint;
   logic [MODE_W-1:0]        mode;
   logic [PHASE_W-1:0]       phase;
   logic                     run_done;

   modport source (output valid, setpoint, mode, phase, run_done, input ready);
   modport sink   (input valid, setpoint, mode, phase, run_done, output ready);
endinterface

// register write channel
interface tps_csr_if
   import tps_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/thermal_profile_sequencer.sv =====
// ----------------------------------------------------------------------------
// thermal_profile_sequencer: heater setpoint sequencer
// Steps isometric and thermal step profiles on measured-temperature ticks.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one command per transfer: a tick with the measured
//   temperature, a start of isometric or step mode, or a setpoint write.
//   Every command yields exactly one transfer on rsp_ch with the setpoint,
//   mode, phase and a run_done flag for the tick that ended a run.
//   csr_ch writes the five profile registers; it is always ready and a write
//   to an index past the list is dropped. Write registers only while idle.
// Result timing and throughput:
//   The result of a command appears on rsp_ch in the cycle after its transfer.
//   One command per cycle is sustained while rsp_ch keeps ready high: the
//   state update is a single pass of compare/add logic, and the result register
//   frees in the same cycle that rsp_ch takes its contents.
// Reset (synchronous, active high):
//   Mode idle, setpoint 25 C, registers at their defaults, rsp_ch empty.
// Stall:
//   While rsp_ch holds an untaken result, req_ch.ready follows rsp_ch.ready,
//   so no result is dropped and commands wait at the input.
// ----------------------------------------------------------------------------
module thermal_profile_sequencer
   import tps_pkg::*;
#(
   parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND,
   parameter int SETTLE_TICKS     = DEF_SETTLE_TICKS,
   parameter int BAND_WIDTH       = DEF_BAND_WIDTH,
   parameter int COOL_TARGET      = DEF_COOL_TARGET
)
(
   input  logic      clock,
   input  logic      reset,
   tps_req_if.sink   req_ch,
   tps_rsp_if.source rsp_ch,
   tps_csr_if.sink   csr_ch
);

   localparam int XW = TEMP_W + 2;
   localparam logic signed [XW-1:0]       BAND_X   = XW'(BAND_WIDTH);
   localparam logic signed [XW-1:0]       COOL_LIM = XW'(COOL_TARGET + BAND_WIDTH);
   localparam logic signed [TEMP_W-1:0]   COOL_SP  = TEMP_W'(COOL_TARGET);
   localparam logic [SETTLE_W-1:0]        SETTLE_N = SETTLE_W'(SETTLE_TICKS);
   localparam logic [31:0]                TPS_32   = 32'(TICKS_PER_SECOND);

   // profile registers
   logic [CNT_W-1:0]         cycle_count_ff;
   logic [CNT_W-1:0]         hold_seconds_ff;
   logic signed [TEMP_W-1:0] step_start_ff;
   logic signed [TEMP_W-1:0] step_stop_ff;
   logic [STEP_W-1:0]        step_size_ff;

   // sequencer state
   mode_type                 mode_ff, mode_in;
   phase_type                phase_ff, phase_in;
   logic [SETTLE_W-1:0]      settle_ff, settle_in;
   logic [HOLD_W-1:0]        hold_ff, hold_in;
   logic [CNT_W-1:0]         cycles_ff, cycles_in;
   logic signed [TEMP_W-1:0] target_ff, target_in;
   logic signed [TEMP_W-1:0] cur_ff, cur_in;
   logic signed [TEMP_W-1:0] lo_ff, lo_in;
   logic signed [TEMP_W-1:0] hi_ff, hi_in;
   logic                     up_ff, up_in;
   logic signed [TEMP_W-1:0] sp_ff, sp_in;
   logic                     done_in;

   // result register
   logic                     rsp_valid_ff;
   logic signed [TEMP_W-1:0] rsp_sp_ff, rsp_sp_in;
   mode_type                 rsp_mode_ff, rsp_mode_in;
   phase_type                rsp_phase_ff, rsp_phase_in;
   logic                     rsp_done_ff;

   logic req_fire;
   op_type op;

   // datapath terms
   logic signed [XW-1:0]     meas_x, sp_x, cur_x, lo_x, hi_x, st_x;
   logic signed [XW-1:0]     d_sp, d_cur, up_raw, dn_raw;
   logic signed [TEMP_W-1:0] up_clamp, dn_clamp;
   logic                     band_sp, band_cur, cool_ok, settle_ok, settled;
   logic [SETTLE_W-1:0]      settle_next;
   logic [31:0]              hold_prod;
   logic [HOLD_W-1:0]        hold_load;
   logic [CNT_W-1:0]         cyc_dec;
   logic                     cyc_last;
   logic [STEP_W-1:0]        st;
   logic signed [TEMP_W-1:0] range_lo, range_hi;

   // handshakes
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign op           = op_type'(req_ch.operation);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_count_ff  <= '0;
         hold_seconds_ff <= '0;
         step_start_ff   <= RST_STEP_LO;
         step_stop_ff    <= RST_STEP_HI;
         step_size_ff    <= RST_STEP_SIZE;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_CYCLE_COUNT:  cycle_count_ff  <= csr_ch.data;
            CSR_HOLD_SECONDS: hold_seconds_ff <= csr_ch.data;
            CSR_STEP_START:   step_start_ff   <= csr_ch.data;
            CSR_STEP_STOP:    step_stop_ff    <= csr_ch.data;
            CSR_STEP_SIZE:    step_size_ff    <= csr_ch.data[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // shared compare, count and step arithmetic
   always_comb begin
      meas_x = {{2{req_ch.measured_temp[TEMP_W-1]}}, req_ch.measured_temp};
      sp_x   = {{2{sp_ff[TEMP_W-1]}}, sp_ff};
      cur_x  = {{2{cur_ff[TEMP_W-1]}}, cur_ff};
      lo_x   = {{2{lo_ff[TEMP_W-1]}}, lo_ff};
      hi_x   = {{2{hi_ff[TEMP_W-1]}}, hi_ff};

      d_sp     = meas_x - sp_x;
      d_cur    = meas_x - cur_x;
      band_sp  = (d_sp <= BAND_X) && (d_sp >= -BAND_X);
      band_cur = (d_cur <= BAND_X) && (d_cur >= -BAND_X);
      cool_ok  = meas_x <= COOL_LIM;

      // settle counter, saturating
      settle_ok = (phase_ff == PH_COOL) ? cool_ok : band_sp;
      if (!settle_ok)
         settle_next = '0;
      else if (settle_ff < SETTLE_SAT)
         settle_next = settle_ff + 1'b1;
      else
         settle_next = settle_ff;
      settled = settle_next >= SETTLE_N;

      // hold length, saturating
      hold_prod = {16'd0, hold_seconds_ff} * TPS_32;
      hold_load = (hold_prod > {9'd0, HOLD_MAX}) ? HOLD_MAX : hold_prod[HOLD_W-1:0];

      // cycle countdown
      cyc_dec  = (cycles_ff != '0) ? cycles_ff - 1'b1 : '0;
      cyc_last = cyc_dec == '0;

      // next step positions, clamped to the range
      st     = (step_size_ff == '0) ? STEP_ZERO_SUBST : step_size_ff;
      st_x   = {3'd0, st};
      up_raw = cur_x + st_x;
      dn_raw = cur_x - st_x;
      if (up_raw > hi_x)      up_clamp = hi_ff;
      else if (up_raw < lo_x) up_clamp = lo_ff;
      else                    up_clamp = up_raw[TEMP_W-1:0];
      if (dn_raw > hi_x)      dn_clamp = hi_ff;
      else if (dn_raw < lo_x) dn_clamp = lo_ff;
      else                    dn_clamp = dn_raw[TEMP_W-1:0];

      // start command normalizes the range order
      if (step_stop_ff < step_start_ff) begin
         range_lo = step_stop_ff;
         range_hi = step_start_ff;
      end else begin
         range_lo = step_start_ff;
         range_hi = step_stop_ff;
      end
   end

   // next state
   always_comb begin
      mode_in   = mode_ff;
      phase_in  = phase_ff;
      settle_in = settle_ff;
      hold_in   = hold_ff;
      cycles_in = cycles_ff;
      target_in = target_ff;
      cur_in    = cur_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      up_in     = up_ff;
      sp_in     = sp_ff;
      done_in   = 1'b0;

      unique case (op)
         OP_TICK: begin
            priority if (mode_ff == MODE_ISO) begin
               unique case (phase_ff)
                  PH_HEAT: begin
                     settle_in = settle_next;
                     if (settled) begin
                        hold_in  = hold_load;
                        phase_in = PH_HOLD;
                     end
                  end
                  PH_HOLD: begin
                     if (hold_ff != '0) begin
                        hold_in = hold_ff - 1'b1;
                     end else begin
                        sp_in     = COOL_SP;
                        settle_in = '0;
                        phase_in  = PH_COOL;
                     end
                  end
                  default: begin
                     settle_in = settle_next;
                     if (settled) begin
                        cycles_in = cyc_dec;
                        if (cyc_last) begin
                           mode_in = MODE_IDLE;
                           done_in = 1'b1;
                        end else begin
                           sp_in     = target_ff;
                           settle_in = '0;
                           phase_in  = PH_HEAT;
                        end
                     end
                  end
               endcase
            end else if (mode_ff == MODE_STEP) begin
               if (phase_ff != PH_HOLD) begin
                  // approach: one tick in band starts the hold
                  if (band_cur) begin
                     hold_in  = hold_load;
                     phase_in = PH_HOLD;
                  end
               end else if (hold_ff != '0) begin
                  hold_in = hold_ff - 1'b1;
               end else begin
                  phase_in = PH_HEAT;
                  priority if (up_ff && (cur_ff < hi_ff)) begin
                     cur_in = up_clamp;
                  end else if (up_ff) begin
                     up_in  = 1'b0;
                     cur_in = dn_clamp;
                  end else if (cur_ff > lo_ff) begin
                     cur_in = dn_clamp;
                  end else begin
                     // bottom of the walk closes one cycle
                     cycles_in = cyc_dec;
                     if (cyc_last) begin
                        mode_in  = MODE_IDLE;
                        phase_in = phase_ff;
                        done_in  = 1'b1;
                     end else begin
                        up_in  = 1'b1;
                        cur_in = up_clamp;
                     end
                  end
                  if (!done_in) sp_in = cur_in;
               end
            end else begin
               // idle tick: nothing changes
            end
         end
         OP_ISO: begin
            cycles_in = cycle_count_ff;
            settle_in = '0;
            hold_in   = '0;
            target_in = sp_ff;
            phase_in  = PH_HEAT;
            mode_in   = MODE_ISO;
         end
         OP_STEP: begin
            cycles_in = cycle_count_ff;
            lo_in     = range_lo;
            hi_in     = range_hi;
            cur_in    = range_lo;
            up_in     = 1'b1;
            sp_in     = range_lo;
            hold_in   = '0;
            phase_in  = PH_HEAT;
            mode_in   = MODE_STEP;
         end
         default: begin
            sp_in = req_ch.setpoint_value;
         end
      endcase
   end

   // result fields
   always_comb begin
      rsp_sp_in    = sp_in;
      rsp_mode_in  = mode_in;
      rsp_phase_in = (mode_in == MODE_IDLE) ? PH_HEAT : phase_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         phase_ff  <= PH_HEAT;
         settle_ff <= '0;
         hold_ff   <= '0;
         cycles_ff <= '0;
         target_ff <= RST_TARGET;
         cur_ff    <= RST_STEP_LO;
         lo_ff     <= RST_STEP_LO;
         hi_ff     <= RST_STEP_HI;
         up_ff     <= 1'b1;
         sp_ff     <= RST_SETPOINT;
      end else if (req_fire) begin
         mode_ff   <= mode_in;
         phase_ff  <= phase_in;
         settle_ff <= settle_in;
         hold_ff   <= hold_in;
         cycles_ff <= cycles_in;
         target_ff <= target_in;
         cur_ff    <= cur_in;
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         up_ff     <= up_in;
         sp_ff     <= sp_in;
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_sp_ff    <= rsp_sp_in;
         rsp_mode_ff  <= rsp_mode_in;
         rsp_phase_ff <= rsp_phase_in;
         rsp_done_ff  <= done_in;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.setpoint = rsp_sp_ff;
   assign rsp_ch.mode     = rsp_mode_ff;
   assign rsp_ch.phase    = rsp_phase_ff;
   assign rsp_ch.run_done = rsp_done_ff;

   // a run end always reports idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> rsp_mode_ff == MODE_IDLE)
      else $error("run_done reported with a running mode");

   // step range stays ordered and the position stays within it
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (lo_ff <= hi_ff) && (cur_ff >= lo_ff) && (cur_ff <= hi_ff))
      else $error("step position outside of step range");

   // settle counter never passes saturation
   a_settle_sat: assert property (@(posedge clock) disable iff (reset)
      settle_ff <= SETTLE_SAT)
      else $error("settle counter past saturation");

   // start commands enter their mode
   a_start_iso: assert property (@(posedge clock) disable iff (reset)
      req_fire && (op == OP_ISO) |=> mode_ff == MODE_ISO && phase_ff == PH_HEAT)
      else $error("isometric start did not take effect");

   a_start_step: assert property (@(posedge clock) disable iff (reset)
      req_fire && (op == OP_STEP) |=> mode_ff == MODE_STEP && sp_ff == lo_ff)
      else $error("step start did not take effect");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: thermal profile sequencer testbench
// Drives commands, register writes and response stalls. A command-level model
// of the sequencer predicts the response of every accepted command, and each
// response is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb
   import tps_pkg::*;
   ();

   localparam int BAND       = DEF_BAND_WIDTH;
   localparam int COOL_LIMIT = DEF_COOL_TARGET + DEF_BAND_WIDTH;
   localparam int RUN_LIMIT  = 600000;
   localparam int MAX_TICKS  = 600;
   localparam logic [CSR_IDX_W-1:0] CSR_PAST_END = 3'd5;

   typedef struct packed {
      logic signed [TEMP_W-1:0] setpoint;
      mode_type                 mode;
      phase_type                phase;
      logic                     run_done;
   } seq_report_type;

   logic clock;
   logic reset;

   tps_req_if req_ch ();
   tps_rsp_if rsp_ch ();
   tps_csr_if csr_ch ();

   thermal_profile_sequencer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // profile registers as the model sees them
   logic [CNT_W-1:0]         cfg_cycles;
   logic [CNT_W-1:0]         cfg_hold_sec;
   logic signed [TEMP_W-1:0] cfg_lo;
   logic signed [TEMP_W-1:0] cfg_hi;
   logic [STEP_W-1:0]        cfg_step;

   // sequencer state
   mode_type                 seq_mode;
   phase_type                seq_phase;
   logic [SETTLE_W-1:0]      settle_cnt;
   logic [HOLD_W-1:0]        hold_cnt;
   logic [CNT_W-1:0]         cycles_left;
   logic signed [TEMP_W-1:0] target_t;
   logic signed [TEMP_W-1:0] step_pos;
   logic signed [TEMP_W-1:0] lo_eff;
   logic signed [TEMP_W-1:0] hi_eff;
   logic                     rising;
   logic signed [TEMP_W-1:0] sp_reg;

   seq_report_type due_reports[$];
   int             fail_count;
   int             items_sent;
   int             cycle_total;
   int             send_idle_pct;
   int             recv_stall_pct;

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run limit
   always @(posedge clock) begin
      cycle_total++;
      if (cycle_total >= RUN_LIMIT) begin
         $display("%0t: timeout, %0d responses outstanding", $time, due_reports.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response backpressure
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ------------------------------------------------------------------------
   // sequencer model
   // ------------------------------------------------------------------------
   function automatic void model_reset();
      cfg_cycles   = '0;
      cfg_hold_sec = '0;
      cfg_lo       = RST_STEP_LO;
      cfg_hi       = RST_STEP_HI;
      cfg_step     = RST_STEP_SIZE;
      seq_mode     = MODE_IDLE;
      seq_phase    = PH_HEAT;
      settle_cnt   = '0;
      hold_cnt     = '0;
      cycles_left  = '0;
      target_t     = RST_TARGET;
      step_pos     = RST_STEP_LO;
      lo_eff       = RST_STEP_LO;
      hi_eff       = RST_STEP_HI;
      rising       = 1'b1;
      sp_reg       = RST_SETPOINT;
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_CYCLE_COUNT:  cfg_cycles = data;
         CSR_HOLD_SECONDS: cfg_hold_sec = data;
         CSR_STEP_START:   cfg_lo = data;
         CSR_STEP_STOP:    cfg_hi = data;
         CSR_STEP_SIZE:    cfg_step = data[STEP_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic bit in_band(int meas, int tgt);
      return (meas - tgt <= BAND) && (tgt - meas <= BAND);
   endfunction

   function automatic void arm_hold();
      int t;
      t = int'(cfg_hold_sec) * DEF_TICKS_PER_SECOND;
      hold_cnt = (t > int'(HOLD_MAX)) ? HOLD_MAX : 23'(t);
   endfunction

   function automatic void settle_track(bit ok);
      if (!ok)
         settle_cnt = '0;
      else if (settle_cnt < SETTLE_SAT)
         settle_cnt++;
   endfunction

   function automatic void step_goto(int nxt);
      if (nxt > int'(hi_eff))
         nxt = hi_eff;
      if (nxt < int'(lo_eff))
         nxt = lo_eff;
      step_pos  = 16'(nxt);
      sp_reg    = step_pos;
      seq_phase = PH_HEAT;
   endfunction

   // one isometric tick, returns 1 when the run ends
   function automatic bit iso_tick(logic signed [TEMP_W-1:0] meas);
      case (seq_phase)
         PH_HEAT: begin
            settle_track(in_band(meas, sp_reg));
            if (settle_cnt >= DEF_SETTLE_TICKS) begin
               arm_hold();
               seq_phase = PH_HOLD;
            end
         end
         PH_HOLD: begin
            if (hold_cnt > 0) begin
               hold_cnt--;
            end else begin
               sp_reg     = DEF_COOL_TARGET;
               settle_cnt = '0;
               seq_phase  = PH_COOL;
            end
         end
         default: begin
            settle_track(int'(meas) <= COOL_LIMIT);
            if (settle_cnt >= DEF_SETTLE_TICKS) begin
               if (cycles_left > 0)
                  cycles_left--;
               if (cycles_left == 0) begin
                  seq_mode = MODE_IDLE;
                  return 1'b1;
               end
               sp_reg     = target_t;
               settle_cnt = '0;
               seq_phase  = PH_HEAT;
            end
         end
      endcase
      return 1'b0;
   endfunction

   // one step-mode tick, returns 1 when the run ends
   function automatic bit step_tick(logic signed [TEMP_W-1:0] meas);
      int st;
      st = (cfg_step == 0) ? 100 : int'(cfg_step);
      if (seq_phase != PH_HOLD) begin
         if (in_band(meas, step_pos)) begin
            arm_hold();
            seq_phase = PH_HOLD;
         end
         return 1'b0;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         return 1'b0;
      end
      if (rising) begin
         if (step_pos < hi_eff) begin
            step_goto(int'(step_pos) + st);
         end else begin
            rising = 1'b0;
            step_goto(int'(step_pos) - st);
         end
      end else if (step_pos > lo_eff) begin
         step_goto(int'(step_pos) - st);
      end else begin
         if (cycles_left > 0)
            cycles_left--;
         if (cycles_left == 0) begin
            seq_mode = MODE_IDLE;
            return 1'b1;
         end
         rising = 1'b1;
         step_goto(int'(step_pos) + st);
      end
      return 1'b0;
   endfunction

   function automatic seq_report_type advance_sequencer(op_type op,
                                                        logic signed [TEMP_W-1:0] meas,
                                                        logic signed [TEMP_W-1:0] val);
      seq_report_type r;
      bit             finished;
      int             a;
      int             b;
      finished = 1'b0;
      case (op)
         OP_TICK: begin
            if (seq_mode == MODE_ISO)
               finished = iso_tick(meas);
            else if (seq_mode == MODE_STEP)
               finished = step_tick(meas);
         end
         OP_ISO: begin
            cycles_left = cfg_cycles;
            settle_cnt  = '0;
            hold_cnt    = '0;
            target_t    = sp_reg;
            seq_phase   = PH_HEAT;
            seq_mode    = MODE_ISO;
         end
         OP_STEP: begin
            a = cfg_lo;
            b = cfg_hi;
            if (b < a) begin
               a = cfg_hi;
               b = cfg_lo;
            end
            cycles_left = cfg_cycles;
            lo_eff      = 16'(a);
            hi_eff      = 16'(b);
            step_pos    = 16'(a);
            rising      = 1'b1;
            sp_reg      = 16'(a);
            hold_cnt    = '0;
            seq_phase   = PH_HEAT;
            seq_mode    = MODE_STEP;
         end
         default: sp_reg = val;
      endcase
      r.setpoint = sp_reg;
      r.mode     = seq_mode;
      r.phase    = (seq_mode == MODE_IDLE) ? PH_HEAT : seq_phase;
      r.run_done = finished;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // transfer monitor: check responses, then predict new commands
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      seq_report_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_reports.size() == 0) begin
               fail_count++;
               $display("%0t: response with none expected, setpoint %0d mode %0d",
                        $time, rsp_ch.setpoint, rsp_ch.mode);
            end else begin
               want = due_reports.pop_front();
               if (rsp_ch.setpoint !== want.setpoint) begin
                  fail_count++;
                  $display("%0t: setpoint expected %0d, got %0d",
                           $time, want.setpoint, rsp_ch.setpoint);
               end
               if (rsp_ch.mode !== want.mode) begin
                  fail_count++;
                  $display("%0t: mode expected %0d, got %0d", $time, want.mode, rsp_ch.mode);
               end
               if (rsp_ch.phase !== want.phase) begin
                  fail_count++;
                  $display("%0t: phase expected %0d, got %0d", $time, want.phase, rsp_ch.phase);
               end
               if (rsp_ch.run_done !== want.run_done) begin
                  fail_count++;
                  $display("%0t: run_done expected %0d, got %0d",
                           $time, want.run_done, rsp_ch.run_done);
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            due_reports.push_back(advance_sequencer(op_type'(req_ch.operation),
                                                    req_ch.measured_temp,
                                                    req_ch.setpoint_value));
         if (csr_ch.valid && csr_ch.ready)
            apply_csr(csr_ch.index, csr_ch.data);
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [TEMP_W-1:0] rand16();
      return 16'($urandom);
   endfunction

   // measured temperature in or out of the band the sequencer waits for
   function automatic logic signed [TEMP_W-1:0] pick_temp(bit want_in);
      int tgt;
      int v;
      if ($urandom_range(99) < 2)
         return rand16();
      if (seq_mode == MODE_ISO && seq_phase == PH_COOL) begin
         if (want_in)
            v = COOL_LIMIT - int'($urandom_range(300));
         else
            v = COOL_LIMIT + 1 + int'($urandom_range(300));
      end else begin
         tgt = (seq_mode == MODE_STEP) ? int'(step_pos) : int'(sp_reg);
         if (want_in)
            v = tgt + int'($urandom_range(2 * BAND)) - BAND;
         else if ($urandom_range(1))
            v = tgt + BAND + 1 + int'($urandom_range(200));
         else
            v = tgt - BAND - 1 - int'($urandom_range(200));
      end
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return 16'(v);
   endfunction

   // one command transfer; a tick can pick its temperature once the model is current
   task automatic send_item(op_type op, logic signed [TEMP_W-1:0] meas,
                            logic signed [TEMP_W-1:0] val,
                            bit auto_temp = 1'b0, bit want_in = 1'b1);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20)
         gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      if (auto_temp)
         meas = pick_temp(want_in);
      req_ch.valid          <= 1'b1;
      req_ch.operation      <= op;
      req_ch.measured_temp  <= meas;
      req_ch.setpoint_value <= val;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      items_sent++;
   endtask

   // stop sending and wait for every outstanding response
   task automatic wait_results_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (due_reports.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // one profile run with random registers, ticks and interruptions
   task automatic run_profile(int goal);
      bit               iso;
      int               roll;
      int               st;
      int               base;
      int               lo;
      int               hi;
      int               ticks;
      int               noise_pct;
      logic [CSR_DATA_W-1:0] size_data;
      iso = $urandom_range(1);
      wait_results_drained();

      roll = $urandom_range(99);
      write_reg(CSR_CYCLE_COUNT, (roll < 3) ? 16'hFFFF : 16'($urandom_range(iso ? 2 : 3)));
      roll = $urandom_range(99);
      if (roll < 85)
         write_reg(CSR_HOLD_SECONDS, 16'd0);
      else if (roll < 97)
         write_reg(CSR_HOLD_SECONDS, 16'd1);
      else
         write_reg(CSR_HOLD_SECONDS, rand16());

      // step size, zero stands for 1 C
      roll = $urandom_range(99);
      if (roll < 20)
         size_data = '0;
      else if (roll < 30)
         size_data = rand16();
      else
         size_data = 16'($urandom_range(50, 2000));
      write_reg(CSR_STEP_SIZE, size_data);
      st = (size_data[STEP_W-1:0] == 0) ? 100 : int'(size_data[STEP_W-1:0]);

      // step range, sometimes at the rails, sometimes reversed
      if ($urandom_range(99) < 10) begin
         lo = $urandom_range(1) ? -32768 : 32767;
         hi = $urandom_range(1) ? -32768 : 32767;
      end else begin
         base = int'($urandom_range(12000)) - 2000;
         lo   = base;
         hi   = base + st * int'($urandom_range(4)) + int'($urandom_range(st));
         if (hi > 32767)
            hi = 32767;
         if ($urandom_range(99) < 30) begin
            lo = hi;
            hi = base;
         end
      end
      write_reg(CSR_STEP_START, 16'(lo));
      write_reg(CSR_STEP_STOP, 16'(hi));
      if ($urandom_range(99) < 5)
         write_reg(CSR_PAST_END + 3'($urandom_range(2)), rand16());

      if (iso && $urandom_range(1))
         send_item(OP_SETPOINT, rand16(), ($urandom_range(9) == 0) ? rand16()
                                          : 16'($urandom_range(1500, 9000)));
      send_item(iso ? OP_ISO : OP_STEP, rand16(), rand16());

      noise_pct = ($urandom_range(99) < 30) ? 8 : 1;
      ticks = 0;
      while (seq_mode != MODE_IDLE && ticks < MAX_TICKS && items_sent < goal) begin
         roll = $urandom_range(999);
         if (roll < 20) begin
            send_item(OP_SETPOINT, rand16(), ($urandom_range(4) == 0) ? rand16()
                                             : 16'($urandom_range(1500, 9000)));
         end else if (roll < 28) begin
            send_item($urandom_range(1) ? OP_ISO : OP_STEP, rand16(), rand16());
         end else begin
            send_item(OP_TICK, '0, rand16(), 1'b1, $urandom_range(99) >= noise_pct);
            ticks++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // ticks and setpoint writes while idle
   task automatic test_idle_items();
      send_item(OP_TICK, 16'sh8000, rand16());
      send_item(OP_TICK, 16'sh7FFF, rand16());
      send_item(OP_SETPOINT, rand16(), 16'sh8000);
      send_item(OP_SETPOINT, rand16(), 16'sh7FFF);
   endtask

   // reversed full-scale range with the largest step, then a zero step
   task automatic test_step_corners();
      wait_results_drained();
      write_reg(CSR_CYCLE_COUNT, 16'd0);
      write_reg(CSR_HOLD_SECONDS, 16'd0);
      write_reg(CSR_STEP_START, 16'h7FFF);
      write_reg(CSR_STEP_STOP, 16'h8000);
      write_reg(CSR_STEP_SIZE, 16'h7FFF);
      write_reg(CSR_PAST_END, 16'hFFFF);
      send_item(OP_STEP, rand16(), rand16());
      send_item(OP_TICK, 16'sh7FFF, rand16());
      repeat (8) send_item(OP_TICK, '0, rand16(), 1'b1, 1'b1);
      wait_results_drained();
      write_reg(CSR_STEP_SIZE, 16'd0);
      send_item(OP_STEP, rand16(), rand16());
      repeat (2) send_item(OP_TICK, '0, rand16(), 1'b1, 1'b1);
   endtask

   // isometric start, setpoint write during a run, restarts of both kinds
   task automatic test_iso_corners();
      wait_results_drained();
      write_reg(CSR_CYCLE_COUNT, 16'hFFFF);
      write_reg(CSR_HOLD_SECONDS, 16'hFFFF);
      send_item(OP_SETPOINT, rand16(), 16'sd4000);
      send_item(OP_ISO, rand16(), rand16());
      send_item(OP_TICK, 16'sh8000, rand16());
      send_item(OP_TICK, '0, rand16(), 1'b1, 1'b1);
      send_item(OP_SETPOINT, rand16(), 16'sh7FFF);
      send_item(OP_ISO, rand16(), rand16());
      send_item(OP_TICK, '0, rand16(), 1'b1, 1'b1);
      send_item(OP_STEP, rand16(), rand16());
   endtask

   task automatic test_random_profiles(int goal, int idle_pct, int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      while (items_sent < goal)
         run_profile(goal);
      wait_results_drained();
   endtask

   initial begin
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.operation      = OP_TICK;
      req_ch.measured_temp  = '0;
      req_ch.setpoint_value = '0;
      rsp_ch.ready          = 1'b0;
      csr_ch.valid          = 1'b0;
      csr_ch.index          = CSR_CYCLE_COUNT;
      csr_ch.data           = '0;
      fail_count            = 0;
      items_sent            = 0;
      cycle_total           = 0;
      send_idle_pct         = 0;
      recv_stall_pct        = 0;
      model_reset();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_items();
      test_step_corners();
      test_iso_corners();
      test_random_profiles(260, 0, 0);
      test_random_profiles(500, 68, 0);
      test_random_profiles(740, 0, 68);
      test_random_profiles(960, 12, 12);

      wait_results_drained();
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/tps_pkg.sv
src/tps_ifs.sv
src/thermal_profile_sequencer.sv
tb/tb.sv
